// File: design/rloop_window_free_energy_assert.svh
`ifndef RLOOP_WINDOW_FREE_ENERGY_ASSERT_SVH
`define RLOOP_WINDOW_FREE_ENERGY_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define RWFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define RWFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rwfe_pkg.sv
`default_nettype none

package rwfe_pkg;

	localparam int DEF_MAX_BASES = 4096;

	// Field widths
	localparam int BASE_W    = 2;
	localparam int TORSION_W = 24;
	localparam int HOOKE_W   = 24;
	localparam int ALPHA_W   = 27;
	localparam int TURNS_W   = 16;
	localparam int PAIR_W    = 21;
	localparam int E_W       = 48;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 27;

	localparam logic [CFG_IDX_W-1:0] REG_TORSION    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOOKE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TURNS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNCONSTR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OVR_ENABLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OVR_ENERGY = 3'd6;

	// Register defaults
	localparam logic [TORSION_W-1:0]      TORSION_RST = 24'd117965;
	localparam logic [HOOKE_W-1:0]        HOOKE_RST   = 24'd59173;
	localparam logic signed [ALPHA_W-1:0] ALPHA_RST   = -27'sd661662;
	localparam logic [TURNS_W-1:0]        TURNS_RST   = 16'd6302;

	// Superhelical term arithmetic
	localparam int FRAC_W      = 16;
	localparam int FOURPI2_W   = 22;
	localparam logic [FOURPI2_W-1:0] FOURPI2_Q16 = 22'd2587258;
	localparam int DIV_STEPS   = 32;
	localparam int TERM_SHIFT  = 33;
	localparam int TERM_OV_BIT = 80;

	localparam logic signed [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
	localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

	// Dinucleotide energies, indexed {earlier base, later base}, Q16.16
	localparam logic signed [PAIR_W-1:0] PAIR_TABLE [16] = '{
		-21'sd23593, -21'sd10486, -21'sd6554,  -21'sd3932,
		 21'sd63570,  21'sd22282,  21'sd29491,  21'sd24904,
		-21'sd7864,  -21'sd10486,  21'sd39322, -21'sd7864,
		 21'sd29491,  21'sd32768,  21'sd18350,  21'sd52429
	};

	typedef struct packed {
		logic start;
		logic div;
	} rwfe_cmd_t;

	typedef struct packed {
		logic [TORSION_W-1:0]      torsion;
		logic [HOOKE_W-1:0]        hooke;
		logic signed [ALPHA_W-1:0] alpha;
		logic [TURNS_W-1:0]        turns;
	} rwfe_helix_cfg_t;

	typedef struct packed {
		logic                  done;
		logic                  ov;
		logic signed [E_W-1:0] term;
	} rwfe_term_t;

	// Clamp a one-bit-grown sum to the energy range; returns {overflow, value}
	function automatic logic [E_W:0] sat_e(input logic signed [E_W:0] v);
		logic [E_W:0] r;
		if (v[E_W] != v[E_W-1]) begin
			r = {1'b1, (v[E_W] ? E_MIN : E_MAX)};
		end else begin
			r = {1'b0, v[E_W-1:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/rwfe_base_if.sv
`default_nettype none

interface rwfe_base_if
	import rwfe_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] base_code;
	logic              window_end;

	modport source (output valid, base_code, window_end, input ready);
	modport sink (input valid, base_code, window_end, output ready);
endinterface

`default_nettype wire

// File: design/rwfe_energy_if.sv
`default_nettype none

interface rwfe_energy_if
	import rwfe_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic signed [E_W-1:0] energy_value;
	logic                  energy_overflow;

	modport source (output valid, energy_value, energy_overflow, input ready);
	modport sink (input valid, energy_value, energy_overflow, output ready);
endinterface

`default_nettype wire

// File: design/rloop_window_free_energy.sv
// Throughput: one base per cycle while a window is open.
// Closing base: the superhelical term runs on a one-bit-per-cycle shift-add/subtract unit.
//   With unconstrained_mode set the term is skipped and the sum goes to the output register once it is free.
// Bases are not taken from a closing base until its result enters the output register.
// Reset (arst_n low, asynchronous): registers to defaults, window state and output valid cleared.
`default_nettype none

module rloop_window_free_energy
	import rwfe_pkg::*;
#(
	parameter int MAX_BASES = DEF_MAX_BASES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rwfe_base_if.sink             base_in,
	rwfe_energy_if.source         energy_out
);
	localparam int CW = $clog2(MAX_BASES + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BASES);

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_TERM = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	// Configuration registers
	logic [TORSION_W-1:0]      torsion_q;
	logic [HOOKE_W-1:0]        hooke_q;
	logic signed [ALPHA_W-1:0] alpha_q;
	logic [TURNS_W-1:0]        turns_q;
	logic                      unc_q;
	logic                      ovr_en_q;
	logic signed [PAIR_W-1:0]  ovr_e_q;

	// Window state and output register
	logic [1:0]             state_q;
	logic [BASE_W-1:0]      prev_q;
	logic                   have_q;
	logic [CW-1:0]          count_q;
	logic signed [E_W-1:0]  sum_q;
	logic                   ovs_q;
	logic signed [E_W-1:0]  term_q;
	logic                   term_ov_q;
	logic                   out_valid_q;
	logic signed [E_W-1:0]  out_e_q;
	logic                   out_ov_q;

	logic                   in_fire;
	logic                   out_free;
	logic [CW-1:0]          count_nx;
	logic signed [PAIR_W-1:0] pair_e;
	logic signed [E_W:0]    pair_add;
	logic [E_W:0]           pair_sat;
	logic signed [E_W:0]    fin_add;
	logic [E_W:0]           fin_sat;

	rwfe_helix_cfg_t hx_cfg;
	rwfe_term_t      hx_res;
	logic            hx_start;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torsion_q <= TORSION_RST;
			hooke_q   <= HOOKE_RST;
			alpha_q   <= ALPHA_RST;
			turns_q   <= TURNS_RST;
			unc_q     <= 1'b0;
			ovr_en_q  <= 1'b0;
			ovr_e_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TORSION:    torsion_q <= cfg_data[TORSION_W-1:0];
				REG_HOOKE:      hooke_q   <= cfg_data[HOOKE_W-1:0];
				REG_ALPHA:      alpha_q   <= cfg_data[ALPHA_W-1:0];
				REG_TURNS:      turns_q   <= cfg_data[TURNS_W-1:0];
				REG_UNCONSTR:   unc_q     <= cfg_data[0];
				REG_OVR_ENABLE: ovr_en_q  <= cfg_data[0];
				REG_OVR_ENERGY: ovr_e_q   <= cfg_data[PAIR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign base_in.ready = (state_q == ST_RUN);
	assign in_fire       = base_in.valid && base_in.ready;
	assign out_free      = !out_valid_q || energy_out.ready;
	assign count_nx      = (count_q < COUNT_MAX) ? count_q + 1'b1 : count_q;

	// Pair energy lookup and saturating sums
	assign pair_e   = ovr_en_q ? ovr_e_q : PAIR_TABLE[{prev_q, base_in.base_code}];
	assign pair_add = {sum_q[E_W-1], sum_q}
		+ {{(E_W+1-PAIR_W){pair_e[PAIR_W-1]}}, pair_e};
	assign pair_sat = sat_e(pair_add);
	assign fin_add  = {sum_q[E_W-1], sum_q} + {term_q[E_W-1], term_q};
	assign fin_sat  = sat_e(fin_add);

	// Superhelical term
	assign hx_start       = in_fire && base_in.window_end && !unc_q;
	assign hx_cfg.torsion = torsion_q;
	assign hx_cfg.hooke   = hooke_q;
	assign hx_cfg.alpha   = alpha_q;
	assign hx_cfg.turns   = turns_q;

	rwfe_helix #(
		.MAX_BASES(MAX_BASES)
	) u_helix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hx_start),
		.m      (count_nx),
		.cfg    (hx_cfg),
		.res    (hx_res)
	);

	// Accumulate bases, wait for the term, then hand the total to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			prev_q      <= '0;
			have_q      <= 1'b0;
			count_q     <= '0;
			sum_q       <= '0;
			ovs_q       <= 1'b0;
			term_q      <= '0;
			term_ov_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_e_q     <= '0;
			out_ov_q    <= 1'b0;
		end else begin
			if (energy_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (in_fire) begin
						if (have_q) begin
							sum_q <= pair_sat[E_W-1:0];
							ovs_q <= ovs_q | pair_sat[E_W];
						end
						prev_q  <= base_in.base_code;
						have_q  <= 1'b1;
						count_q <= count_nx;
						if (base_in.window_end) begin
							term_q    <= '0;
							term_ov_q <= 1'b0;
							state_q   <= unc_q ? ST_FIN : ST_TERM;
						end
					end
				end
				ST_TERM: begin
					if (hx_res.done) begin
						term_q    <= hx_res.term;
						term_ov_q <= hx_res.ov;
						state_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_e_q     <= fin_sat[E_W-1:0];
						out_ov_q    <= ovs_q | term_ov_q | fin_sat[E_W];
						prev_q      <= '0;
						have_q      <= 1'b0;
						count_q     <= '0;
						sum_q       <= '0;
						ovs_q       <= 1'b0;
						state_q     <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign energy_out.valid           = out_valid_q;
	assign energy_out.energy_value    = out_e_q;
	assign energy_out.energy_overflow = out_ov_q;
endmodule

`default_nettype wire

// File: design/rwfe_shift_unit.sv
`default_nettype none

// One bit per cycle: shift-add multiply (multiplier MSB first) or restoring divide
module rwfe_shift_unit
	import rwfe_pkg::*;
#(
	parameter int UW = TERM_OV_BIT + 1,
	parameter int OB = DIV_STEPS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rwfe_cmd_t       cmd,
	input  logic [UW-1:0]   a,
	input  logic [OB-1:0]   b,
	input  logic [UW-1:0]   init,
	output logic            done,
	output logic [UW-1:0]   acc,
	output logic [OB-1:0]   quo
);
	localparam int CNT_W = $clog2(OB);

	logic [UW-1:0]    acc_q;
	logic [UW-1:0]    opa_q;
	logic [OB-1:0]    opb_q;
	logic [CNT_W-1:0] cnt_q;
	logic             div_q;
	logic             busy_q;
	logic             done_q;

	logic [UW-1:0] sh;
	logic [UW-1:0] addend;
	logic [UW:0]   sum;
	logic          qbit;
	logic [UW-1:0] acc_nx;

	// Shared adder: add the multiplicand, or subtract the divisor
	assign sh     = {acc_q[UW-2:0], 1'b0};
	assign addend = div_q ? ~opa_q : (opb_q[OB-1] ? opa_q : '0);
	assign sum    = {1'b0, sh} + {1'b0, addend} + (UW+1)'(div_q);
	assign qbit   = div_q & sum[UW];
	assign acc_nx = (div_q && !sum[UW]) ? sh : sum[UW-1:0];

	// Load on start, then step until the count runs out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			opa_q  <= '0;
			opb_q  <= '0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			acc_q  <= cmd.div ? init : '0;
			opa_q  <= a;
			opb_q  <= b;
			div_q  <= cmd.div;
			cnt_q  <= cmd.div ? CNT_W'(DIV_STEPS - 1) : CNT_W'(OB - 1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
			opb_q <= {opb_q[OB-2:0], qbit};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
	assign quo  = opb_q;
endmodule

`default_nettype wire

// File: design/rwfe_helix.sv
`default_nettype none

// Sequencer for the superhelical term 2pi^2Ck(alpha+mA)^2/(4pi^2C+km)
module rwfe_helix
	import rwfe_pkg::*;
#(
	parameter int MAX_BASES = DEF_MAX_BASES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [$clog2(MAX_BASES + 1)-1:0]   m,
	input  rwfe_helix_cfg_t                    cfg,
	output rwfe_term_t                         res
);
	localparam int CW     = $clog2(MAX_BASES + 1);
	localparam int MA_W   = CW + TURNS_W;
	localparam int MAGW   = ((ALPHA_W > MA_W) ? ALPHA_W : MA_W) + 1;
	localparam int SW     = MAGW + 1;
	localparam int P_W    = FOURPI2_W + TORSION_W;
	localparam int KM_W   = HOOKE_W + CW;
	localparam int D_W    = ((P_W > KM_W + FRAC_W) ? P_W : KM_W + FRAC_W) + 1;
	localparam int TW     = HOOKE_W;
	localparam int TM_W   = TW + MAGW;
	localparam int PROD_W = TM_W + MAGW;
	localparam int UW_A   = (D_W + 1 > PROD_W) ? D_W + 1 : PROD_W;
	localparam int UW     = (UW_A > TERM_OV_BIT + 1) ? UW_A : TERM_OV_BIT + 1;
	localparam int OB     = (MAGW > DIV_STEPS) ? MAGW : DIV_STEPS;

	localparam logic [3:0] H_IDLE = 4'd0;
	localparam logic [3:0] H_P    = 4'd1;
	localparam logic [3:0] H_KM   = 4'd2;
	localparam logic [3:0] H_CHK  = 4'd3;
	localparam logic [3:0] H_DIV  = 4'd4;
	localparam logic [3:0] H_RK   = 4'd5;
	localparam logic [3:0] H_MA   = 4'd6;
	localparam logic [3:0] H_S    = 4'd7;
	localparam logic [3:0] H_TM   = 4'd8;
	localparam logic [3:0] H_TMM  = 4'd9;

	logic [3:0]              st_q;
	logic                    go_q;
	logic [CW-1:0]           m_q;
	logic [P_W-1:0]          p_q;
	logic [KM_W-1:0]         km_q;
	logic [DIV_STEPS-1:0]    r_q;
	logic [TW-1:0]           t_q;
	logic [MA_W-1:0]         ma_q;
	logic [MAGW-1:0]         mag_q;
	logic [TM_W-1:0]         tm_q;
	logic signed [E_W-1:0]   term_q;
	logic                    ov_q;
	logic                    done_q;

	rwfe_cmd_t      u_cmd;
	logic [UW-1:0]  u_a;
	logic [OB-1:0]  u_b;
	logic [UW-1:0]  u_init;
	logic           u_done;
	logic [UW-1:0]  u_acc;
	logic [OB-1:0]  u_quo;

	logic [D_W-1:0]        d;
	logic signed [SW-1:0]  s_val;
	logic [SW-1:0]         s_neg;
	logic [MAGW-1:0]       s_mag;
	logic                  prod_ov;

	// Denominator 4pi^2C + km*2^16 and |alpha + m*A|
	assign d     = D_W'(p_q) + (D_W'(km_q) << FRAC_W);
	assign s_val = {{(SW-ALPHA_W){cfg.alpha[ALPHA_W-1]}}, cfg.alpha}
		+ {{(SW-MA_W){1'b0}}, ma_q};
	assign s_neg = -s_val;
	assign s_mag = s_val[SW-1] ? s_neg[MAGW-1:0] : s_val[MAGW-1:0];
	assign prod_ov = |u_acc[UW-1:TERM_OV_BIT];

	// Route operands of the current step to the shared unit
	always_comb begin
		u_a    = '0;
		u_b    = '0;
		u_init = '0;
		case (st_q)
			H_P: begin
				u_a = UW'(FOURPI2_Q16);
				u_b = OB'(cfg.torsion);
			end
			H_KM: begin
				u_a = UW'(cfg.hooke);
				u_b = OB'(m_q);
			end
			H_DIV: begin
				u_a    = UW'(d);
				u_init = UW'(p_q);
			end
			H_RK: begin
				u_a = UW'(cfg.hooke);
				u_b = OB'(r_q);
			end
			H_MA: begin
				u_a = UW'(cfg.turns);
				u_b = OB'(m_q);
			end
			H_TM: begin
				u_a = UW'(t_q);
				u_b = OB'(mag_q);
			end
			H_TMM: begin
				u_a = UW'(tm_q);
				u_b = OB'(mag_q);
			end
			default: begin
			end
		endcase
	end

	assign u_cmd.start = go_q;
	assign u_cmd.div   = (st_q == H_DIV);

	rwfe_shift_unit #(
		.UW(UW),
		.OB(OB)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (u_cmd),
		.a      (u_a),
		.b      (u_b),
		.init   (u_init),
		.done   (u_done),
		.acc    (u_acc),
		.quo    (u_quo)
	);

	// Step through the term, launching the unit on entry to each operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= H_IDLE;
			go_q   <= 1'b0;
			done_q <= 1'b0;
			m_q    <= '0;
			p_q    <= '0;
			km_q   <= '0;
			r_q    <= '0;
			t_q    <= '0;
			ma_q   <= '0;
			mag_q  <= '0;
			tm_q   <= '0;
			term_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (st_q)
				H_IDLE: begin
					if (start) begin
						m_q  <= m;
						st_q <= H_P;
						go_q <= 1'b1;
					end
				end
				H_P: begin
					if (u_done) begin
						p_q  <= u_acc[P_W-1:0];
						st_q <= H_KM;
						go_q <= 1'b1;
					end
				end
				H_KM: begin
					if (u_done) begin
						km_q <= u_acc[KM_W-1:0];
						st_q <= H_CHK;
					end
				end
				H_CHK: begin
					// km of zero: ratio is one (t = k), or zero denominator
					if (km_q == '0) begin
						if (p_q == '0) begin
							term_q <= '0;
							ov_q   <= 1'b0;
							done_q <= 1'b1;
							st_q   <= H_IDLE;
						end else begin
							t_q  <= cfg.hooke;
							st_q <= H_MA;
							go_q <= 1'b1;
						end
					end else begin
						st_q <= H_DIV;
						go_q <= 1'b1;
					end
				end
				H_DIV: begin
					if (u_done) begin
						r_q  <= u_quo[DIV_STEPS-1:0];
						st_q <= H_RK;
						go_q <= 1'b1;
					end
				end
				H_RK: begin
					if (u_done) begin
						t_q  <= u_acc[DIV_STEPS+TW-1:DIV_STEPS];
						st_q <= H_MA;
						go_q <= 1'b1;
					end
				end
				H_MA: begin
					if (u_done) begin
						ma_q <= u_acc[MA_W-1:0];
						st_q <= H_S;
					end
				end
				H_S: begin
					mag_q <= s_mag;
					st_q  <= H_TM;
					go_q  <= 1'b1;
				end
				H_TM: begin
					if (u_done) begin
						tm_q <= u_acc[TM_W-1:0];
						st_q <= H_TMM;
						go_q <= 1'b1;
					end
				end
				H_TMM: begin
					if (u_done) begin
						ov_q   <= prod_ov;
						term_q <= prod_ov ? E_MAX : E_W'(u_acc[TERM_OV_BIT-1:TERM_SHIFT]);
						done_q <= 1'b1;
						st_q   <= H_IDLE;
					end
				end
				default: begin
					st_q <= H_IDLE;
				end
			endcase
		end
	end

	assign res.done = done_q;
	assign res.ov   = ov_q;
	assign res.term = term_q;
endmodule

`default_nettype wire

// File: design/rwfe_checker.sv
`default_nettype none

`include "rloop_window_free_energy_assert.svh"

module rwfe_checker
	import rwfe_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  in_window_end,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic signed [E_W-1:0] energy_value,
	input logic                  energy_overflow
);
	// Hold a stalled result
	`RWFE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`RWFE_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(energy_value) && $stable(energy_overflow), "result changed while stalled")

	// A closing base stops the input until its result is out
	`RWFE_ASSERT_NEXT(a_busy_after_end, clk, arst_n, in_valid && in_ready && in_window_end, !in_ready, "input open after closing base")

	// A new result only appears after a busy cycle
	`RWFE_ASSERT_SAME(a_result_after_busy, clk, arst_n, $rose(out_valid), !$past(in_ready), "result without a closed window")
endmodule

bind rloop_window_free_energy rwfe_checker u_rwfe_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (base_in.valid),
	.in_ready        (base_in.ready),
	.in_window_end   (base_in.window_end),
	.out_valid       (energy_out.valid),
	.out_ready       (energy_out.ready),
	.energy_value    (energy_out.energy_value),
	.energy_overflow (energy_out.energy_overflow)
);

`default_nettype wire

// File: dv/rloop_window_free_energy_tb.sv
`default_nettype none

module rloop_window_free_energy_tb;
	import rwfe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WINDOW = 4096;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam logic [63:0] FOUR_PI_SQ = 64'd2587258;
	localparam longint ENERGY_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint ENERGY_MIN = -ENERGY_MAX - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic [1:0] {BASE_C, BASE_G, BASE_T, BASE_A} base_t;
	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		logic       hold;
		logic [1:0] code;
		logic       last;
	} base_item_t;

	typedef struct packed {
		logic signed [E_W-1:0] energy_value;
		logic                  energy_overflow;
	} energy_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rwfe_base_if base_if ();
	rwfe_energy_if energy_if ();

	rloop_window_free_energy #(
		.MAX_BASES(MAX_WINDOW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.base_in(base_if.sink),
		.energy_out(energy_if.source)
	);

	always #4 clk = ~clk;

	// Bases waiting to be sent and window energies waiting to come back
	base_item_t base_stream[$];
	energy_result_t pending_energies[$];
	int mismatches = 0;

	// Shadow of the configuration registers
	logic [23:0] cfg_torsion;
	logic [23:0] cfg_hooke;
	longint cfg_alpha;
	logic [15:0] cfg_turns;
	logic cfg_unconstrained;
	logic cfg_ovr_en;
	longint cfg_ovr_energy;

	// Open window
	logic [1:0] win_prev;
	logic win_open;
	int unsigned win_len;
	longint win_sum;
	logic win_ovf;

	int burst_left;
	int gap_left;
	rx_mode_t rx_mode;
	int rx_span;
	int quiet_cycles;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: %s", $time, what);
	endtask

	// Stacking energy of a dinucleotide, earlier base first, Q16.16
	function automatic int dinuc_energy(input logic [1:0] first, input logic [1:0] second);
		case ({first, second})
			{BASE_C, BASE_C}: return -23593;
			{BASE_C, BASE_G}: return -10486;
			{BASE_C, BASE_T}: return -6554;
			{BASE_C, BASE_A}: return -3932;
			{BASE_G, BASE_C}: return 63570;
			{BASE_G, BASE_G}: return 22282;
			{BASE_G, BASE_T}: return 29491;
			{BASE_G, BASE_A}: return 24904;
			{BASE_T, BASE_C}: return -7864;
			{BASE_T, BASE_G}: return -10486;
			{BASE_T, BASE_T}: return 39322;
			{BASE_T, BASE_A}: return -7864;
			{BASE_A, BASE_C}: return 29491;
			{BASE_A, BASE_G}: return 32768;
			{BASE_A, BASE_T}: return 18350;
			default: return 52429;
		endcase
	endfunction

	function automatic longint clamp_energy(input longint v);
		if (v > ENERGY_MAX) begin
			win_ovf = 1'b1;
			return ENERGY_MAX;
		end
		if (v < ENERGY_MIN) begin
			win_ovf = 1'b1;
			return ENERGY_MIN;
		end
		return v;
	endfunction

	// Superhelical term 2pi^2*C*k*(alpha+m*A)^2 / (4pi^2*C + k*m), Q16.16
	function automatic longint helix_energy(input int unsigned m);
		logic [63:0] p;
		logic [63:0] d;
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] mag;
		logic [95:0] quot;
		logic [127:0] prod;
		longint s;
		p = 64'(cfg_torsion) * FOUR_PI_SQ;
		d = p + ((64'(cfg_hooke) * 64'(m)) << 16);
		if (d == 64'd0) return 0;
		if (p >= d) begin
			r = 64'd1 << 32;
		end else begin
			quot = {p, 32'd0} / {32'd0, d};
			r = quot[63:0];
		end
		t = (r * 64'(cfg_hooke)) >> 32;
		s = cfg_alpha + longint'(m) * longint'(cfg_turns);
		mag = (s < 0) ? 64'(-s) : 64'(s);
		prod = 128'(t * mag) * 128'(mag);
		if (prod[127:80] != '0) begin
			win_ovf = 1'b1;
			return ENERGY_MAX;
		end
		return longint'({17'd0, prod[79:33]});
	endfunction

	// Fold one accepted base into the window; close it on the last base
	function automatic void predict_base(input logic [1:0] code, input logic last);
		longint pair_e;
		longint total;
		energy_result_t res;
		if (win_open) begin
			pair_e = cfg_ovr_en ? cfg_ovr_energy : longint'(dinuc_energy(win_prev, code));
			win_sum = clamp_energy(win_sum + pair_e);
		end
		win_prev = code;
		win_open = 1'b1;
		if (win_len < MAX_WINDOW) win_len++;
		if (last) begin
			total = win_sum;
			if (!cfg_unconstrained) total = clamp_energy(total + helix_energy(win_len));
			res.energy_value = total[E_W-1:0];
			res.energy_overflow = win_ovf;
			pending_energies.push_back(res);
			win_prev = '0;
			win_open = 1'b0;
			win_len = 0;
			win_sum = 0;
			win_ovf = 1'b0;
		end
	endfunction

	function automatic void queue_base(input logic [1:0] code, input logic last);
		base_item_t item;
		item.hold = 1'b0;
		item.code = code;
		item.last = last;
		base_stream.push_back(item);
	endfunction

	// Marker: the sender holds off until every window energy has come back
	function automatic void queue_pause();
		base_item_t item;
		item = '0;
		item.hold = 1'b1;
		base_stream.push_back(item);
	endfunction

	task automatic queue_random_windows(input int n_items);
		int len;
		int sent;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) queue_base(2'($urandom_range(0, 3)), i == len - 1);
			sent += len;
			if ($urandom_range(0, 19) == 0) queue_pause();
		end
	endtask

	task automatic queue_long_window(input int len);
		for (int i = 0; i < len; i++) queue_base(2'($urandom_range(0, 3)), i == len - 1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TORSION: cfg_torsion = val[23:0];
			REG_HOOKE: cfg_hooke = val[23:0];
			REG_ALPHA: cfg_alpha = longint'(signed'(val[26:0]));
			REG_TURNS: cfg_turns = val[15:0];
			REG_UNCONSTR: cfg_unconstrained = val[0];
			REG_OVR_ENABLE: cfg_ovr_en = val[0];
			REG_OVR_ENERGY: cfg_ovr_energy = longint'(signed'(val[20:0]));
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [26:0] torsion, input logic [26:0] hooke,
			input logic [26:0] alpha, input logic [26:0] turns, input logic unconstr,
			input logic ovr_en, input logic [26:0] ovr_energy);
		write_reg(REG_TORSION, torsion);
		write_reg(REG_HOOKE, hooke);
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_TURNS, turns);
		write_reg(REG_UNCONSTR, {26'd0, unconstr});
		write_reg(REG_OVR_ENABLE, {26'd0, ovr_en});
		write_reg(REG_OVR_ENERGY, ovr_energy);
	endtask

	// Wait until everything sent has come back, then let the block go quiet
	task automatic drain();
		while (!(base_stream.size() == 0 && !base_if.valid && pending_energies.size() == 0))
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Base sender: bursts of transfers with random gaps
	always @(posedge clk or negedge arst_n) begin : base_driver
		base_item_t nxt;
		if (!arst_n) begin
			base_if.valid <= 1'b0;
			base_if.base_code <= '0;
			base_if.window_end <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (base_if.valid && base_if.ready) predict_base(base_if.base_code, base_if.window_end);
			if (!base_if.valid || base_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					base_if.valid <= 1'b0;
				end else if (base_stream.size() != 0 && base_stream[0].hold) begin
					base_if.valid <= 1'b0;
					if (pending_energies.size() == 0) void'(base_stream.pop_front());
				end else if (base_stream.size() != 0) begin
					nxt = base_stream.pop_front();
					base_if.valid <= 1'b1;
					base_if.base_code <= nxt.code;
					base_if.window_end <= nxt.last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 31);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					base_if.valid <= 1'b0;
				end
			end
		end
	end

	// Energy receiver: check each transfer, stall in changing modes
	always @(posedge clk or negedge arst_n) begin : energy_monitor
		energy_result_t want;
		if (!arst_n) begin
			energy_if.ready <= 1'b0;
			rx_mode = RX_FREE;
			rx_span = 0;
		end else begin
			if (energy_if.valid && energy_if.ready) begin
				if (pending_energies.size() == 0) begin
					report_mismatch($sformatf("unexpected energy %0d",
						energy_if.energy_value));
				end else begin
					want = pending_energies.pop_front();
					if (energy_if.energy_value !== want.energy_value)
						report_mismatch($sformatf("energy_value got %0d want %0d",
							energy_if.energy_value, want.energy_value));
					if (energy_if.energy_overflow !== want.energy_overflow)
						report_mismatch($sformatf("energy_overflow got %0b want %0b",
							energy_if.energy_overflow, want.energy_overflow));
				end
			end
			if (rx_span == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_span = $urandom_range(8, 80);
			end else begin
				rx_span--;
			end
			case (rx_mode)
				RX_COIN: energy_if.ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: energy_if.ready <= ($urandom_range(0, 3) == 0);
				default: energy_if.ready <= 1'b1;
			endcase
		end
	end

	// Abort when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (base_if.valid && base_if.ready) || (energy_if.valid && energy_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		base_if.valid = 1'b0;
		base_if.base_code = '0;
		base_if.window_end = 1'b0;
		energy_if.ready = 1'b0;
		quiet_cycles = 0;
		cfg_torsion = 24'd117965;
		cfg_hooke = 24'd59173;
		cfg_alpha = -661662;
		cfg_turns = 16'd6302;
		cfg_unconstrained = 1'b0;
		cfg_ovr_en = 1'b0;
		cfg_ovr_energy = 0;
		win_prev = '0;
		win_open = 1'b0;
		win_len = 0;
		win_sum = 0;
		win_ovf = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Every dinucleotide once in one window, then one-base windows and a two-base window
		queue_base(BASE_C, 1'b0);
		queue_base(BASE_C, 1'b0);
		queue_base(BASE_G, 1'b0);
		queue_base(BASE_C, 1'b0);
		queue_base(BASE_T, 1'b0);
		queue_base(BASE_C, 1'b0);
		queue_base(BASE_A, 1'b0);
		queue_base(BASE_G, 1'b0);
		queue_base(BASE_G, 1'b0);
		queue_base(BASE_T, 1'b0);
		queue_base(BASE_G, 1'b0);
		queue_base(BASE_A, 1'b0);
		queue_base(BASE_T, 1'b0);
		queue_base(BASE_T, 1'b0);
		queue_base(BASE_A, 1'b0);
		queue_base(BASE_A, 1'b0);
		queue_base(BASE_C, 1'b1);
		queue_pause();
		queue_base(BASE_A, 1'b1);
		queue_base(BASE_C, 1'b1);
		queue_base(BASE_A, 1'b0);
		queue_base(BASE_A, 1'b1);
		queue_random_windows(80);

		// Override energy at both ends of its range
		drain();
		write_all(27'd117965, 27'd59173, 27'h75E662, 27'd6302, 1'b0, 1'b1, 27'h0FFFFF);
		queue_random_windows(50);
		drain();
		write_reg(REG_OVR_ENERGY, 27'h100000);
		queue_random_windows(50);

		// Pair sum only
		drain();
		write_all(27'($urandom()), 27'($urandom()), 27'($urandom()), 27'($urandom()),
			1'b1, 1'b0, 27'($urandom()));
		queue_random_windows(60);

		// All zero: the denominator vanishes
		drain();
		write_all('0, '0, '0, '0, 1'b0, 1'b0, '0);
		queue_random_windows(60);

		// Largest stiffness, coefficient and turns, linking difference of -1; one window longer than the rest
		drain();
		write_all(27'hFFFFFF, 27'hFFFFFF, 27'h3FFFFFF, 27'hFFFF, 1'b0, 1'b0, '0);
		queue_random_windows(40);
		queue_long_window(80);

		// No Hooke term, most negative linking difference
		drain();
		write_all(27'hFFFFFF, '0, 27'h4000000, '0, 1'b0, 1'b1, 27'($urandom()));
		queue_random_windows(40);

		// Random settings, full data width, and a write to the unused index
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_all(27'($urandom()), 27'($urandom()), 27'($urandom()), 27'($urandom()),
				1'($urandom()), 1'($urandom()), 27'($urandom()));
			write_reg(REG_UNUSED, 27'($urandom()));
			queue_random_windows(60);
		end

		drain();
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
